// ===== src/sws_pkg.sv =====
`timescale 1ns / 1ps
// sws_pkg: types, codes and byte classes for the shell word splitter
// depends on nothing; used by every other file of the block but sws_in_if
package sws_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_WEND = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  // quote modes; the fourth code is never entered and acts as unquoted, save that a 0 in it is an error
  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [1:0] quote_mode;
    logic       esc_pending;
    logic       esc_in_double;
    logic       word_open;
    logic       glob_flag;
  } split_state_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_out;
    logic       glob_wanted;
    logic       last;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_wild(input logic [7:0] c);
    return (c == CH_STAR) || (c == CH_QMARK) || (c == CH_LBRACK);
  endfunction

endpackage

// ===== src/sws_in_if.sv =====
`timescale 1ns / 1ps
// sws_in_if: byte channel into the splitter (valid, ready, one byte)
// no dependencies
interface sws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

// ===== src/sws_out_if.sv =====
`timescale 1ns / 1ps
// sws_out_if: result channel out of the splitter
// depends on sws_pkg for the kind codes
interface sws_out_if;
  logic           valid;
  logic           ready;
  sws_pkg::kind_e kind;
  logic [7:0]     char_out;
  logic           glob_wanted;
  logic           last;

  modport source (output valid, output kind, output char_out, output glob_wanted,
                  output last, input ready);
  modport sink (input valid, input kind, input char_out, input glob_wanted,
                input last, output ready);
endinterface

// ===== src/sws_decode.sv =====
`timescale 1ns / 1ps
// sws_decode: next state and up to two results for one input byte
// depends on sws_pkg
module sws_decode (
  input  logic [7:0]            char_i,
  input  sws_pkg::split_state_t cur_i,
  output sws_pkg::split_state_t nxt_o,
  output logic [1:0]            res_cnt_o,
  output sws_pkg::result_t      res0_o,
  output sws_pkg::result_t      res1_o
);
  import sws_pkg::*;

  always_comb begin
    nxt_o     = cur_i;
    res_cnt_o = 2'd0;
    res0_o    = '0;
    res1_o    = '0;

    if (char_i == CH_NUL) begin
      if ((cur_i.quote_mode != QM_NONE) || cur_i.esc_pending) begin
        res0_o.kind = KIND_ERR;
        res_cnt_o   = 2'd1;
      end else if (cur_i.word_open) begin
        res0_o.kind        = KIND_WEND;
        res0_o.glob_wanted = cur_i.glob_flag;
        res1_o.kind        = KIND_DONE;
        res_cnt_o          = 2'd2;
      end else begin
        res0_o.kind = KIND_DONE;
        res_cnt_o   = 2'd1;
      end
      nxt_o = '0;
    end else if (cur_i.esc_pending) begin
      // escaped wildcard outside double quotes cancels globbing
      if (!cur_i.esc_in_double && is_wild(char_i)) begin
        nxt_o.glob_flag = 1'b0;
      end
      nxt_o.esc_pending   = 1'b0;
      nxt_o.esc_in_double = 1'b0;
      nxt_o.word_open     = 1'b1;
      res0_o.kind         = KIND_CHAR;
      res0_o.char_out     = char_i;
      res_cnt_o           = 2'd1;
    end else if (cur_i.quote_mode == QM_SINGLE) begin
      if (char_i == CH_SQUOTE) begin
        nxt_o.quote_mode = QM_NONE;
      end else begin
        res0_o.kind     = KIND_CHAR;
        res0_o.char_out = char_i;
        res_cnt_o       = 2'd1;
      end
    end else if (cur_i.quote_mode == QM_DOUBLE) begin
      if (char_i == CH_DQUOTE) begin
        nxt_o.quote_mode = QM_NONE;
      end else if (char_i == CH_BSLASH) begin
        nxt_o.esc_pending   = 1'b1;
        nxt_o.esc_in_double = 1'b1;
      end else begin
        res0_o.kind     = KIND_CHAR;
        res0_o.char_out = char_i;
        res_cnt_o       = 2'd1;
      end
    end else begin
      nxt_o.quote_mode = QM_NONE;
      if (is_blank(char_i)) begin
        if (cur_i.word_open) begin
          res0_o.kind        = KIND_WEND;
          res0_o.glob_wanted = cur_i.glob_flag;
          res_cnt_o          = 2'd1;
          nxt_o.word_open    = 1'b0;
          nxt_o.glob_flag    = 1'b0;
        end
      end else if (char_i == CH_BSLASH) begin
        nxt_o.esc_pending   = 1'b1;
        nxt_o.esc_in_double = 1'b0;
        nxt_o.word_open     = 1'b1;
      end else if (char_i == CH_SQUOTE) begin
        nxt_o.quote_mode = QM_SINGLE;
        nxt_o.word_open  = 1'b1;
      end else if (char_i == CH_DQUOTE) begin
        nxt_o.quote_mode = QM_DOUBLE;
        nxt_o.word_open  = 1'b1;
      end else begin
        if (is_wild(char_i)) begin
          nxt_o.glob_flag = 1'b1;
        end
        nxt_o.word_open = 1'b1;
        res0_o.kind     = KIND_CHAR;
        res0_o.char_out = char_i;
        res_cnt_o       = 2'd1;
      end
    end

    // mark the final result of this byte
    if (res_cnt_o == 2'd1) begin
      res0_o.last = 1'b1;
    end
    if (res_cnt_o == 2'd2) begin
      res1_o.last = 1'b1;
    end
  end

endmodule

// ===== src/sws_result_fifo.sv =====
`timescale 1ns / 1ps
// sws_result_fifo: small result queue taking up to two entries a cycle
// depends on sws_pkg
module sws_result_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             push_cnt_i,
  input  sws_pkg::result_t       push0_i,
  input  sws_pkg::result_t       push1_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  logic                   pop_i,
  output sws_pkg::result_t       head_o
);
  import sws_pkg::*;

  result_t             mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                pop;

  // room for a worst case transaction of two results
  assign space_o = (count_q <= CntW'(FifoDepth - 2));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push1_i;
    end
  end

endmodule

// ===== src/shell_word_splitter.sv =====
`timescale 1ns / 1ps
// shell_word_splitter: splits a zero-terminated byte string into shell words
// channels: char_i (bytes in, sink) and res_o (results out, source)
// depends on sws_pkg, sws_in_if, sws_out_if, sws_decode, sws_result_fifo
//
// usage: send the string one byte per transaction on char_i, ending with 0.
// each byte yields zero, one or two results on res_o: word characters, a word
// end carrying the glob flag, then a done or a syntax error for the final 0.
// the last result a byte causes has last set.
// results enter a four-entry result queue and leave it on res_o in order.
// throughput: one byte per cycle while the queue has two free entries; the
// final 0 can give two results, which drain one per cycle while res_o.ready.
// char_i.ready depends only on queue occupancy (two free entries), so a
// stalled receiver fills the queue and then holds off new bytes; nothing is
// lost. reset clears the quoting and word state and empties the queue.
module shell_word_splitter (
  input  logic      clk_i,
  input  logic      rst_ni,
  sws_in_if.sink    char_i,
  sws_out_if.source res_o
);
  import sws_pkg::*;

  split_state_t state_q, state_d;
  logic [1:0]   res_cnt;
  logic [1:0]   push_cnt;
  result_t      res0, res1, head;
  logic         in_acc;
  logic         space;
  logic         head_valid;

  assign char_i.ready = space;
  assign in_acc       = char_i.valid && space;
  assign push_cnt     = in_acc ? res_cnt : 2'd0;

  sws_decode u_decode (
    .char_i    (char_i.char_in),
    .cur_i     (state_q),
    .nxt_o     (state_d),
    .res_cnt_o (res_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  sws_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .space_o    (space),
    .valid_o    (head_valid),
    .pop_i      (res_o.ready),
    .head_o     (head)
  );

  assign res_o.valid       = head_valid;
  assign res_o.kind        = head.kind;
  assign res_o.char_out    = head.char_out;
  assign res_o.glob_wanted = head.glob_wanted;
  assign res_o.last        = head.last;

  // end of string always closes the transaction's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && ((res_o.kind == KIND_DONE) || (res_o.kind == KIND_ERR)) |-> res_o.last)
    else $error("done or error result without last");

  // terminating byte returns all state to its reset value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (char_i.char_in == CH_NUL) |=> (state_q == '0))
    else $error("state not cleared after end of string");

  // the double-quote escape marker only lives alongside a pending escape
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.esc_in_double |-> state_q.esc_pending)
    else $error("escape_in_double without escape_pending");

  // only the terminating byte may give two results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (char_i.char_in != CH_NUL) |-> (res_cnt != 2'd2))
    else $error("two results from a non-terminating byte");

endmodule
